// ===== sv/tbrw_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tbrw_pkg: shared definitions of the tiled blit rectangle walker
// Coordinate width, port widths, register indexes and the command and status
// bundles that pass between controller and datapath.
// ---------------------------------------------------------------------------
package tbrw_pkg;

    // Coordinate width, 8 to 16 bits
    localparam int COORD_BITS = 16;

    // Fixed widths of the port words
    localparam int SRC_W      = 16;
    localparam int DST_W      = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int HALF_W     = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ORIGIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_ORIGIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_SIZE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_OFFSET   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FLIP_MODE     = 3'd5;

    // Controller to datapath
    typedef struct packed {
        logic start_div;   // launch the offset remainder for both axes
        logic load_start;  // take normalized first tile into start and cursor
        logic emit;        // clip the tile at the cursor, load output, advance
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic div_done;    // remainders are ready
        logic out_free;    // output register empty or taken this cycle
        logic last;        // tile at the cursor closes the pass
    } ctrl_stat_t;

endpackage

// ===== sv/tbrw_ifs.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tbrw_ifs: channel interfaces of the tiled blit rectangle walker
// Request, tile result and register write channels, each a valid/ready pair
// with its payload.
// ---------------------------------------------------------------------------
interface tbrw_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface tbrw_tile_if;
    logic                       valid;
    logic                       ready;
    logic [tbrw_pkg::SRC_W-1:0] src_x;
    logic [tbrw_pkg::SRC_W-1:0] src_y;
    logic [tbrw_pkg::SRC_W-1:0] src_w;
    logic [tbrw_pkg::SRC_W-1:0] src_h;
    logic [tbrw_pkg::DST_W-1:0] dst_x;
    logic [tbrw_pkg::DST_W-1:0] dst_y;
    logic [tbrw_pkg::SRC_W-1:0] dst_w;
    logic [tbrw_pkg::SRC_W-1:0] dst_h;
    logic                       mirror_h;
    logic                       mirror_v;
    logic                       last_tile;

    modport source (output valid, output src_x, output src_y, output src_w, output src_h,
                    output dst_x, output dst_y, output dst_w, output dst_h,
                    output mirror_h, output mirror_v, output last_tile, input ready);
    modport sink   (input valid, input src_x, input src_y, input src_w, input src_h,
                    input dst_x, input dst_y, input dst_w, input dst_h,
                    input mirror_h, input mirror_v, input last_tile, output ready);
endinterface

interface tbrw_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tbrw_pkg::CFG_IDX_W-1:0]  index;
    logic [tbrw_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/tiled_blit_rect_walker_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tiled_blit_rect_walker_top: tile command generator of a tiling blitter
// Walks the tiles of a source rectangle across a destination rectangle in
// row-major order and gives each one clipped, placed and mirrored.
//
//   channel  dir  handshake      word
//   req      in   valid/ready    restart
//   tile     out  valid/ready    src x/y/w/h, dst x/y/w/h, mirror h/v, last
//   cfg      in   valid/ready    index, data (ready held high)
//
// A request within a pass gives its tile in the output register in the cycle
// after it is taken. A request that opens a pass first runs the bit-serial
// remainder units that normalize the tiling offset, then loads and emits its tile.
// Requests are taken only while no pass is being opened and the output
// register is empty or being read.
// Reset is asynchronous, active low; no pass is under way after it.
// ---------------------------------------------------------------------------
module tiled_blit_rect_walker_top (
    input  logic         clk,
    input  logic         rst_n,
    tbrw_req_if.sink     req,
    tbrw_tile_if.source  tile,
    tbrw_cfg_if.sink     cfg
);
    tbrw_pkg::ctrl_cmd_t  cmd;
    tbrw_pkg::ctrl_stat_t stat;
    logic                 cfg_we;
    logic                 cfg_hit;

    // Register writes are always taken; only known indexes end the pass
    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && cfg.ready;
    assign cfg_hit   = cfg_we && (cfg.index <= tbrw_pkg::REG_FLIP_MODE);

    tbrw_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_hit (cfg_hit),
        .req     (req),
        .cmd     (cmd),
        .stat    (stat)
    );

    tbrw_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .cmd       (cmd),
        .stat      (stat),
        .tile      (tile)
    );

    // A request is taken only when the output word has room
    assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> (!tile.valid || tile.ready))
        else $error("request taken while output word blocked");

    // A request that starts a pass shows no word in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.restart) |=> !tile.valid)
        else $error("tile word appeared before offset normalization");

    // Remainders complete only while the controller waits for them
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_done |-> cmd.load_start)
        else $error("remainder finished outside of normalization");

    // Only one command at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.start_div, cmd.load_start, cmd.emit}))
        else $error("conflicting controller commands");

endmodule

// ===== sv/tbrw_rem.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tbrw_rem: iterative unsigned remainder
// Restoring division, one dividend bit per cycle. Pulses done for one cycle
// with the remainder held afterward.
// ---------------------------------------------------------------------------
module tbrw_rem (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [tbrw_pkg::COORD_BITS-1:0] dividend,
    input  logic [tbrw_pkg::COORD_BITS-1:0] divisor,
    output logic [tbrw_pkg::COORD_BITS-1:0] rem,
    output logic                            done
);
    localparam int CB    = tbrw_pkg::COORD_BITS;
    localparam int CNT_W = $clog2(CB + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CB-1:0]    dvd_reg, dvd_next;
    logic [CB-1:0]    rem_reg, rem_next;
    logic [CB:0]      trial;

    // One restoring step: shift in the next bit, subtract if it fits
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[CB-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(CB);
            dvd_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
                rem_next = CB'(trial - {1'b0, divisor});
            else
                rem_next = trial[CB-1:0];
            dvd_next = {dvd_reg[CB-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

// ===== sv/tbrw_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tbrw_datapath: registers, tile cursor, clipping and output word
// Holds the configuration, normalizes the tiling offset through two remainder
// units, walks the tile cursor and clips each tile into the output register.
// ---------------------------------------------------------------------------
module tbrw_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tbrw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tbrw_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  tbrw_pkg::ctrl_cmd_t              cmd,
    output tbrw_pkg::ctrl_stat_t             stat,
    tbrw_tile_if.source                      tile
);
    localparam int CB = tbrw_pkg::COORD_BITS;
    localparam int HW = tbrw_pkg::HALF_W;

    typedef struct packed {
        logic [CB-1:0] sp;
        logic [CB-1:0] len;
        logic [CB:0]   dp;
    } axis_t;

    // Configuration
    logic [CB-1:0] src_ox_reg, src_oy_reg;
    logic [CB-1:0] tile_w_reg, tile_h_reg;
    logic [CB-1:0] dst_ox_reg, dst_oy_reg;
    logic [CB-1:0] dst_w_reg, dst_h_reg;
    logic [CB-1:0] off_x_reg, off_y_reg;
    logic [1:0]    flip_reg;

    // Walk state
    logic signed [CB:0] start_col_reg, start_row_reg;
    logic signed [CB:0] cur_x_reg, cur_y_reg;
    logic signed [CB:0] start_col_next, start_row_next;
    logic signed [CB:0] cur_x_next, cur_y_next;

    // Output word
    logic          out_valid_reg;
    axis_t         ax_reg, ay_reg;
    logic [1:0]    mir_reg;
    logic          last_reg;

    logic [CB-1:0] lo_half, hi_half;
    logic [CB-1:0] mag_x, mag_y, rem_x, rem_y;
    logic          done_x, done_y;
    logic signed [CB+1:0] nx, ny;
    logic          x_fits, y_fits;
    axis_t         ax, ay;

    // Clip one axis of the tile at local position pos
    function automatic axis_t clip_axis(input logic signed [CB:0] pos,
                                        input logic [CB-1:0] tsize,
                                        input logic [CB-1:0] ext,
                                        input logic [CB-1:0] sorg,
                                        input logic [CB-1:0] dorg,
                                        input logic mir);
        logic signed [CB+1:0] p, ts, ex, under, lpos, endp, lim, len, offs;
        axis_t r;
        p     = {pos[CB], pos};
        ts    = $signed({2'b00, tsize});
        ex    = $signed({2'b00, ext});
        under = p[CB+1] ? -p : '0;
        lpos  = p + under;
        endp  = p + ts;
        lim   = (endp > ex) ? ex : endp;
        len   = lim - lpos;
        offs  = mir ? (ts - under - len) : under;
        r.sp  = sorg + offs[CB-1:0];
        r.len = len[CB-1:0];
        r.dp  = {1'b0, dorg} + lpos[CB:0];
        return r;
    endfunction

    // Size halves of zero count as one
    assign lo_half = cfg_data[CB-1:0];
    assign hi_half = cfg_data[HW +: CB];

    // Take register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_ox_reg <= '0;
            src_oy_reg <= '0;
            tile_w_reg <= CB'(1);
            tile_h_reg <= CB'(1);
            dst_ox_reg <= '0;
            dst_oy_reg <= '0;
            dst_w_reg  <= CB'(1);
            dst_h_reg  <= CB'(1);
            off_x_reg  <= '0;
            off_y_reg  <= '0;
            flip_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tbrw_pkg::REG_SOURCE_ORIGIN:
                begin
                    src_ox_reg <= lo_half;
                    src_oy_reg <= hi_half;
                end
                tbrw_pkg::REG_TILE_SIZE:
                begin
                    tile_w_reg <= (lo_half == '0) ? CB'(1) : lo_half;
                    tile_h_reg <= (hi_half == '0) ? CB'(1) : hi_half;
                end
                tbrw_pkg::REG_DEST_ORIGIN:
                begin
                    dst_ox_reg <= lo_half;
                    dst_oy_reg <= hi_half;
                end
                tbrw_pkg::REG_DEST_SIZE:
                begin
                    dst_w_reg <= (lo_half == '0) ? CB'(1) : lo_half;
                    dst_h_reg <= (hi_half == '0) ? CB'(1) : hi_half;
                end
                tbrw_pkg::REG_TILE_OFFSET:
                begin
                    off_x_reg <= lo_half;
                    off_y_reg <= hi_half;
                end
                tbrw_pkg::REG_FLIP_MODE:
                begin
                    flip_reg <= cfg_data[1:0];
                end
                default:
                begin
                    flip_reg <= flip_reg;
                end
            endcase
        end
    end

    // Remainder of the offset magnitude by the tile size, per axis
    assign mag_x = off_x_reg[CB-1] ? (~off_x_reg + CB'(1)) : off_x_reg;
    assign mag_y = off_y_reg[CB-1] ? (~off_y_reg + CB'(1)) : off_y_reg;

    tbrw_rem u_rem_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start_div),
        .dividend (mag_x),
        .divisor  (tile_w_reg),
        .rem      (rem_x),
        .done     (done_x)
    );

    tbrw_rem u_rem_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start_div),
        .dividend (mag_y),
        .divisor  (tile_h_reg),
        .rem      (rem_y),
        .done     (done_y)
    );

    // Clip the tile at the cursor
    assign ax = clip_axis(cur_x_reg, tile_w_reg, dst_w_reg, src_ox_reg, dst_ox_reg,
                          flip_reg[0]);
    assign ay = clip_axis(cur_y_reg, tile_h_reg, dst_h_reg, src_oy_reg, dst_oy_reg,
                          flip_reg[1]);

    // Step the cursor in row-major order
    assign nx     = {cur_x_reg[CB], cur_x_reg} + $signed({2'b00, tile_w_reg});
    assign ny     = {cur_y_reg[CB], cur_y_reg} + $signed({2'b00, tile_h_reg});
    assign x_fits = nx < $signed({2'b00, dst_w_reg});
    assign y_fits = ny < $signed({2'b00, dst_h_reg});

    always_comb
    begin
        start_col_next = start_col_reg;
        start_row_next = start_row_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        if (cmd.load_start)
        begin
            // First tile lies in (-size, 0], congruent to the offset
            if (rem_x == '0)
                start_col_next = '0;
            else if (off_x_reg[CB-1])
                start_col_next = -$signed({1'b0, rem_x});
            else
                start_col_next = $signed({1'b0, rem_x}) - $signed({1'b0, tile_w_reg});
            if (rem_y == '0)
                start_row_next = '0;
            else if (off_y_reg[CB-1])
                start_row_next = -$signed({1'b0, rem_y});
            else
                start_row_next = $signed({1'b0, rem_y}) - $signed({1'b0, tile_h_reg});
            cur_x_next = start_col_next;
            cur_y_next = start_row_next;
        end
        else if (cmd.emit)
        begin
            if (x_fits)
                cur_x_next = nx[CB:0];
            else if (y_fits)
            begin
                cur_x_next = start_col_reg;
                cur_y_next = ny[CB:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_col_reg <= '0;
            start_row_reg <= '0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
        end
        else
        begin
            start_col_reg <= start_col_next;
            start_row_reg <= start_row_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
        end
    end

    // Hold the output word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (tile.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            ax_reg   <= ax;
            ay_reg   <= ay;
            mir_reg  <= flip_reg;
            last_reg <= stat.last;
        end
    end

    assign stat.div_done = done_x & done_y;
    assign stat.out_free = !out_valid_reg || tile.ready;
    assign stat.last     = !x_fits && !y_fits;

    assign tile.valid     = out_valid_reg;
    assign tile.src_x     = tbrw_pkg::SRC_W'(ax_reg.sp);
    assign tile.src_y     = tbrw_pkg::SRC_W'(ay_reg.sp);
    assign tile.src_w     = tbrw_pkg::SRC_W'(ax_reg.len);
    assign tile.src_h     = tbrw_pkg::SRC_W'(ay_reg.len);
    assign tile.dst_x     = tbrw_pkg::DST_W'(ax_reg.dp);
    assign tile.dst_y     = tbrw_pkg::DST_W'(ay_reg.dp);
    assign tile.dst_w     = tbrw_pkg::SRC_W'(ax_reg.len);
    assign tile.dst_h     = tbrw_pkg::SRC_W'(ay_reg.len);
    assign tile.mirror_h  = mir_reg[0];
    assign tile.mirror_v  = mir_reg[1];
    assign tile.last_tile = last_reg;

endmodule

// ===== sv/tbrw_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tbrw_ctrl: pass controller of the tiled blit rectangle walker
// Accepts requests, runs the offset normalization on a new pass and orders
// one tile out per request. Tracks whether a pass is under way.
// ---------------------------------------------------------------------------
module tbrw_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_hit,
    tbrw_req_if.sink             req,
    output tbrw_pkg::ctrl_cmd_t  cmd,
    input  tbrw_pkg::ctrl_stat_t stat
);
    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   pass_active_reg, pass_active_next;
    logic   accept;

    // Decode commands and next state
    always_comb
    begin
        cmd              = '0;
        state_next       = state_reg;
        pass_active_next = pass_active_reg;
        req.ready        = (state_reg == S_IDLE) && stat.out_free;
        accept           = req.valid && req.ready;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.restart || !pass_active_reg)
                    begin
                        cmd.start_div = 1'b1;
                        state_next    = S_DIV;
                    end
                    else
                    begin
                        cmd.emit = 1'b1;
                        if (stat.last)
                            pass_active_next = 1'b0;
                    end
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.load_start   = 1'b1;
                    pass_active_next = 1'b1;
                    state_next       = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
                if (stat.last)
                    pass_active_next = 1'b0;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // A write to a known register ends the pass
        if (cfg_hit)
            pass_active_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            pass_active_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pass_active_reg <= pass_active_next;
        end
    end

endmodule

// ===== tb/tb_tiled_blit_rect_walker_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_tiled_blit_rect_walker_top: self-checking bench of the tile walker
// Drives tile requests and register writes, predicts every tile word from a
// model of the walk kept inside a small scoreboard, and compares each word
// taken from the tile channel field by field with the oldest prediction.
// Both channel sides idle at random; one long receiver hold fills the block.
// ---------------------------------------------------------------------------
module tb_tiled_blit_rect_walker_top;
    import tbrw_pkg::*;

    localparam int COORD_MASK  = (1 << COORD_BITS) - 1;
    localparam int DST_MASK    = (1 << DST_W) - 1;
    localparam int ITEM_TARGET = 650;
    localparam int TIMEOUT_NS  = 3_000_000;
    localparam int DRAIN_LIMIT = 20000;
    localparam int PRINT_LIMIT = 40;

    // Register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    typedef struct {
        logic [SRC_W-1:0] src_x;
        logic [SRC_W-1:0] src_y;
        logic [SRC_W-1:0] src_w;
        logic [SRC_W-1:0] src_h;
        logic [DST_W-1:0] dst_x;
        logic [DST_W-1:0] dst_y;
        logic [SRC_W-1:0] dst_w;
        logic [SRC_W-1:0] dst_h;
        logic             mirror_h;
        logic             mirror_v;
        logic             last_tile;
    } tile_word_t;

    // Walk predictor and store of expected tile words
    class tile_scoreboard;
        bit [31:0]  src_origin;
        bit [31:0]  tile_dims;
        bit [31:0]  dst_origin;
        bit [31:0]  dst_dims;
        bit [31:0]  offset_word;
        bit [1:0]   flip_bits;
        int         first_col;
        int         first_row;
        int         cur_x;
        int         cur_y;
        bit         in_pass;
        tile_word_t pending_tiles[$];
        int         mismatches;

        function new();
            src_origin  = 0;
            tile_dims   = 32'h0001_0001;
            dst_origin  = 0;
            dst_dims    = 32'h0001_0001;
            offset_word = 0;
            flip_bits   = 0;
            first_col   = 0;
            first_row   = 0;
            cur_x       = 0;
            cur_y       = 0;
            in_pass     = 0;
            mismatches  = 0;
        endfunction

        function int unsigned_half(bit [31:0] r, bit hi);
            bit [31:0] v;
            v = hi ? {16'h0, r[31:16]} : {16'h0, r[15:0]};
            return int'(v & COORD_MASK);
        endfunction

        // A zero size counts as one
        function int size_half(bit [31:0] r, bit hi);
            int v;
            v = unsigned_half(r, hi);
            return (v == 0) ? 1 : v;
        endfunction

        function int signed_half(bit [31:0] r, bit hi);
            int v;
            v = unsigned_half(r, hi);
            if (v >= (1 << (COORD_BITS - 1)))
                v -= (1 << COORD_BITS);
            return v;
        endfunction

        // First tile position: in (-size, 0], congruent to the offset
        function int fold_offset(int offs, int size);
            int m;
            m = offs % size;
            if (m < 0)
                m += size;
            return (m == 0) ? 0 : m - size;
        endfunction

        // Clip one axis of the tile at pos against the destination extent
        function void clip_span(input int pos, input int tsize, input int extent,
                                input int sorg, input int dorg, input bit mirror,
                                output logic [SRC_W-1:0] sp, output logic [SRC_W-1:0] len_o,
                                output logic [DST_W-1:0] dp);
            int under;
            int len;
            int lpos;
            int over;
            int offs;
            int s_abs;
            int d_abs;
            under = (pos < 0) ? -pos : 0;
            len   = tsize - under;
            lpos  = pos + under;
            over  = lpos + len - extent;
            if (over > 0)
                len -= over;
            offs  = mirror ? tsize - under - len : under;
            s_abs = (sorg + offs) & COORD_MASK;
            d_abs = (dorg + lpos) & DST_MASK;
            sp    = s_abs[SRC_W-1:0];
            len_o = len[SRC_W-1:0];
            dp    = d_abs[DST_W-1:0];
        endfunction

        // Any known register ends the pass; unmapped indexes are dropped
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_SOURCE_ORIGIN: src_origin  = data;
                REG_TILE_SIZE:     tile_dims   = data;
                REG_DEST_ORIGIN:   dst_origin  = data;
                REG_DEST_SIZE:     dst_dims    = data;
                REG_TILE_OFFSET:   offset_word = data;
                REG_FLIP_MODE:     flip_bits   = data[1:0];
                default:           return;
            endcase
            in_pass = 0;
        endfunction

        function void predict_tile(bit restart);
            int         tw;
            int         th;
            int         dw;
            int         dh;
            int         nx;
            int         ny;
            tile_word_t t;
            tw = size_half(tile_dims, 0);
            th = size_half(tile_dims, 1);
            dw = size_half(dst_dims, 0);
            dh = size_half(dst_dims, 1);
            // Open a pass on request or when none is under way
            if (restart || !in_pass)
            begin
                first_col = fold_offset(signed_half(offset_word, 0), tw);
                first_row = fold_offset(signed_half(offset_word, 1), th);
                cur_x     = first_col;
                cur_y     = first_row;
                in_pass   = 1;
            end
            clip_span(cur_x, tw, dw, unsigned_half(src_origin, 0), unsigned_half(dst_origin, 0),
                      flip_bits[0], t.src_x, t.src_w, t.dst_x);
            clip_span(cur_y, th, dh, unsigned_half(src_origin, 1), unsigned_half(dst_origin, 1),
                      flip_bits[1], t.src_y, t.src_h, t.dst_y);
            t.dst_w     = t.src_w;
            t.dst_h     = t.src_h;
            t.mirror_h  = flip_bits[0];
            t.mirror_v  = flip_bits[1];
            t.last_tile = 1'b0;
            // Advance in row-major order; close the pass after the last tile
            nx = cur_x + tw;
            if (nx < dw)
            begin
                cur_x = nx;
            end
            else
            begin
                ny = cur_y + th;
                if (ny < dh)
                begin
                    cur_x = first_col;
                    cur_y = ny;
                end
                else
                begin
                    t.last_tile = 1'b1;
                    in_pass     = 0;
                end
            end
            pending_tiles.push_back(t);
        endfunction

        task report(string what, int unsigned got, int unsigned want);
            if (mismatches < PRINT_LIMIT)
                $display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
            mismatches++;
        endtask

        task check_tile(tile_word_t got);
            tile_word_t want;
            if (pending_tiles.size() == 0)
            begin
                report("tile word with none pending", 0, 0);
                return;
            end
            want = pending_tiles.pop_front();
            if (got.src_x !== want.src_x)         report("src_x", got.src_x, want.src_x);
            if (got.src_y !== want.src_y)         report("src_y", got.src_y, want.src_y);
            if (got.src_w !== want.src_w)         report("src_w", got.src_w, want.src_w);
            if (got.src_h !== want.src_h)         report("src_h", got.src_h, want.src_h);
            if (got.dst_x !== want.dst_x)         report("dst_x", got.dst_x, want.dst_x);
            if (got.dst_y !== want.dst_y)         report("dst_y", got.dst_y, want.dst_y);
            if (got.dst_w !== want.dst_w)         report("dst_w", got.dst_w, want.dst_w);
            if (got.dst_h !== want.dst_h)         report("dst_h", got.dst_h, want.dst_h);
            if (got.mirror_h !== want.mirror_h)   report("mirror_h", got.mirror_h, want.mirror_h);
            if (got.mirror_v !== want.mirror_v)   report("mirror_v", got.mirror_v, want.mirror_v);
            if (got.last_tile !== want.last_tile) report("last_tile", got.last_tile, want.last_tile);
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    tbrw_req_if  req_ch();
    tbrw_tile_if tile_ch();
    tbrw_cfg_if  cfg_ch();

    tile_scoreboard sb = new();

    int items_sent = 0;
    bit src_eager  = 1'b0;
    bit sink_eager = 1'b0;
    int sink_hold  = 0;

    tiled_blit_rect_walker_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .tile  (tile_ch),
        .cfg   (cfg_ch)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 0;
    end

    // Predict a tile word for every request taken
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
            sb.predict_tile(req_ch.restart);
    end

    // Mirror every register write into the predictor
    always @(posedge clk)
    begin
        if (rst_n && cfg_ch.valid && cfg_ch.ready)
            sb.write_reg(cfg_ch.index, cfg_ch.data);
    end

    // Check every tile word taken
    always @(posedge clk)
    begin : tile_watch
        tile_word_t seen;
        if (rst_n && tile_ch.valid && tile_ch.ready)
        begin
            seen.src_x     = tile_ch.src_x;
            seen.src_y     = tile_ch.src_y;
            seen.src_w     = tile_ch.src_w;
            seen.src_h     = tile_ch.src_h;
            seen.dst_x     = tile_ch.dst_x;
            seen.dst_y     = tile_ch.dst_y;
            seen.dst_w     = tile_ch.dst_w;
            seen.dst_h     = tile_ch.dst_h;
            seen.mirror_h  = tile_ch.mirror_h;
            seen.mirror_v  = tile_ch.mirror_v;
            seen.last_tile = tile_ch.last_tile;
            sb.check_tile(seen);
        end
    end

    function automatic int draw_gap(bit eager);
        return eager ? 0 : $urandom_range(0, 19);
    endfunction

    function automatic bit [15:0] corner_half();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'h0001;
            2:       return 16'h7FFF;
            3:       return 16'h8000;
            4:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Receiver: random stalls, or a long hold when one is asked for
    initial
    begin : tile_sink
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (sink_hold > 0)
            begin
                stall     = sink_hold;
                sink_hold = 0;
            end
            else
            begin
                stall = draw_gap(sink_eager);
            end
            if (stall > 0)
            begin
                tile_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            tile_ch.ready <= 1'b1;
            do @(posedge clk); while (!tile_ch.valid);
        end
    end

    // Offer one request word; keep valid high when the next follows at once
    task automatic offer_request(input bit restart);
        int gap;
        gap = draw_gap(src_eager);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.restart <= restart;
        do @(posedge clk); while (!req_ch.ready);
        items_sent++;
    endtask

    // Stop requests and wait until every tile word has come back
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (sb.pending_tiles.size() != 0) @(posedge clk);
        repeat (COORD_BITS + 2) @(posedge clk);
    endtask

    task automatic cfg_word(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    task automatic write_one(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        settle();
        cfg_word(idx, data);
        cfg_ch.valid <= 1'b0;
    endtask

    // Load all six registers, optionally followed by a write to an unmapped index
    task automatic program_walker(input bit [31:0] s_org, input bit [31:0] t_dims,
                                  input bit [31:0] d_org, input bit [31:0] d_dims,
                                  input bit [31:0] offs, input bit [31:0] flip,
                                  input bit add_unmapped);
        settle();
        cfg_word(REG_SOURCE_ORIGIN, s_org);
        cfg_word(REG_TILE_SIZE, t_dims);
        cfg_word(REG_DEST_ORIGIN, d_org);
        cfg_word(REG_DEST_SIZE, d_dims);
        cfg_word(REG_TILE_OFFSET, offs);
        cfg_word(REG_FLIP_MODE, flip);
        if (add_unmapped)
            cfg_word($urandom_range(0, 1) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO, $urandom);
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int        kind;
        int        count;
        int        pct;
        int        phase;
        int        n;
        bit [31:0] t_dims;
        bit [31:0] d_dims;
        bit [31:0] offs;
        bit [31:0] s_org;
        bit [31:0] d_org;
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.restart = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = '0;
        cfg_ch.data    = '0;
        tile_ch.ready  = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset sizes: every tick is a one-tile pass, with or without restart
        offer_request(1'b0);
        offer_request(1'b0);
        offer_request(1'b1);

        // Zero sizes count as one; maximum origins; negative offsets; both flips
        program_walker(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
                       32'h8000_8000, 32'h0000_0003, 1'b0);
        offer_request(1'b0);
        offer_request(1'b1);

        // Source wrap under mirroring; walk a 3x3 pass to its end and past it
        program_walker(32'hFFFE_FFFD, 32'h0003_0005, 32'h0001_FFF0, 32'h0007_000B,
                       32'h7FFF_7FFF, 32'h0000_0003, 1'b0);
        repeat (10) offer_request(1'b0);

        // An unmapped write keeps the pass; a real write ends it
        program_walker(32'h1234_0010, 32'h0004_0003, 32'h0020_0008, 32'h0010_000A,
                       32'h0000_0000, 32'h0000_0001, 1'b0);
        offer_request(1'b0);
        offer_request(1'b0);
        write_one(REG_UNMAPPED_LO, $urandom);
        offer_request(1'b0);
        offer_request(1'b0);
        write_one(REG_FLIP_MODE, 32'hFFFF_FFFE);
        offer_request(1'b0);
        offer_request(1'b0);
        offer_request(1'b1);

        // Largest tile on the largest destination
        program_walker(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        repeat (3) offer_request(1'b0);

        // Random phases, mostly small walks that reach their last tile
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            kind = (phase == 1) ? 0 : $urandom_range(0, 9);
            if (kind < 6)
            begin
                t_dims = {16'($urandom_range(0, 9)), 16'($urandom_range(0, 9))};
                d_dims = {16'($urandom_range(0, 20)), 16'($urandom_range(0, 32))};
                offs   = $urandom;
                s_org  = $urandom;
                d_org  = $urandom;
                count  = $urandom_range(30, 70);
                pct    = 4;
            end
            else if (kind < 8)
            begin
                t_dims = $urandom;
                d_dims = $urandom;
                offs   = $urandom;
                s_org  = $urandom;
                d_org  = $urandom;
                count  = $urandom_range(10, 25);
                pct    = 25;
            end
            else
            begin
                t_dims = {corner_half(), corner_half()};
                d_dims = {corner_half(), corner_half()};
                offs   = {corner_half(), corner_half()};
                s_org  = {corner_half(), corner_half()};
                d_org  = {corner_half(), corner_half()};
                count  = $urandom_range(10, 25);
                pct    = 15;
            end
            program_walker(s_org, t_dims, d_org, d_dims, offs, $urandom,
                           $urandom_range(0, 3) == 0);
            src_eager  = ($urandom_range(0, 3) == 0);
            sink_eager = ($urandom_range(0, 3) == 0);
            // Hold the receiver off long enough to back up the request side
            if (phase == 1)
            begin
                src_eager  = 1'b0;
                sink_eager = 1'b0;
                sink_hold  = 300;
            end
            repeat (count) offer_request($urandom_range(0, 99) < pct);
            phase++;
        end

        // Drain, then give the block time to show any stray word
        req_ch.valid <= 1'b0;
        for (n = 0; n < DRAIN_LIMIT && sb.pending_tiles.size() != 0; n++)
            @(posedge clk);
        repeat (COORD_BITS + 4) @(posedge clk);
        if (sb.pending_tiles.size() != 0)
            sb.report("tile words never produced", sb.pending_tiles.size(), 0);

        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Hard stop in case the block hangs
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/tbrw_pkg.sv
sv/tbrw_ifs.sv
sv/tbrw_rem.sv
sv/tbrw_datapath.sv
sv/tbrw_ctrl.sv
sv/tiled_blit_rect_walker_top.sv
tb/tb_tiled_blit_rect_walker_top.sv
